[hw/rtl/elf_pkg.sv]
// ----------------------------------------------------------------------------
// elf_pkg
// Shared constants, types and saturating helpers for the Lax-Friedrichs step.
// ----------------------------------------------------------------------------
package elf_pkg;

    localparam int NUM_VARS      = 3;
    localparam int WORD_BITS_DEF = 32;
    localparam int FRAC_BITS_DEF = 16;

    localparam int IN_BITS   = 31;
    localparam int VEL_BITS  = 32;
    localparam int OUT_BITS  = 32;
    localparam int STEP_BITS = 17;
    localparam int STEP_FRAC = 16;
    localparam logic [STEP_BITS-1:0] STEP_MAX = 17'd65536;

    localparam int EXT_BITS   = 64;
    localparam int MUL_CHUNK  = 24;
    localparam int MUL_B_BITS = 32;
    localparam int Q_DEPTH    = 4;

    localparam logic signed [EXT_BITS-1:0] EXT_ONE  = EXT_BITS'(1);
    localparam logic signed [EXT_BITS-1:0] EXT_ZERO = EXT_BITS'(0);

    typedef struct packed {
        logic signed [EXT_BITS-1:0] val;
        logic                       ov;
    } t_sat;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_flags;

    typedef enum logic [2:0] {
        F_IDLE,
        F_MUL1,
        F_MUL2,
        F_ADD1,
        F_ADD2,
        F_ADD3,
        F_MUL3,
        F_PUSH
    } t_front_state;

    typedef enum logic [2:0] {
        B_IDLE,
        B_ROUTE,
        B_MSTART,
        B_MWAIT,
        B_INTERIOR,
        B_BOUNDARY,
        B_SHIFT
    } t_back_state;

    // clamp to a signed word of the given width
    function automatic t_sat sat_word(input logic signed [EXT_BITS-1:0] x, input int bits);
        t_sat                       r;
        logic signed [EXT_BITS-1:0] hi;
        logic signed [EXT_BITS-1:0] lo;
        hi = (EXT_ONE <<< (bits - 1)) - EXT_ONE;
        lo = -hi - EXT_ONE;
        if (x > hi) begin
            r.val = hi;
            r.ov  = 1'b1;
        end else if (x < lo) begin
            r.val = lo;
            r.ov  = 1'b1;
        end else begin
            r.val = x;
            r.ov  = 1'b0;
        end
        return r;
    endfunction

    function automatic logic signed [EXT_BITS-1:0] abs_ext(input logic signed [EXT_BITS-1:0] x);
        return (x < EXT_ZERO) ? -x : x;
    endfunction

endpackage

[hw/rtl/euler_lax_friedrichs_step.sv]
// ----------------------------------------------------------------------------
// euler_lax_friedrichs_step
// One Lax-Friedrichs step of the 1-D Euler equations over a streamed grid row.
// ----------------------------------------------------------------------------
// Cells enter on the input channel (i_in_valid / o_in_stall) in row order,
// i_row_end marking the last cell. Results leave on the output channel
// (o_out_valid / i_out_stall) in row order; first and last cells come out as
// boundaries, each interior cell one cell late when its right neighbour has
// been formed. A cell can give two results (last interior and last boundary).
// The front takes one cell at a time and forms it with three passes through
// its chunk-serial multiplier, which works in 24-bit chunks. The back runs
// its own multiplier once per variable for a cell with an interior result,
// and handles a boundary that follows as a further step.
// A four-entry queue parts the two, so the front keeps accepting
// while the back waits on a stalled output; o_in_stall is high while the
// front works on a cell, and stays high while the queue is full.
// A result holds on the ports while i_out_stall is high.
// i_cfg_wr_en writes step_factor (values above 1.0 stored as 1.0).
// Synchronous reset empties the queue, clears the window and row count and
// sets step_factor to zero.
// ----------------------------------------------------------------------------
module euler_lax_friedrichs_step
    import elf_pkg::*;
#(
    parameter int WORD_BITS = WORD_BITS_DEF,
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_wr_en,
    input  logic [STEP_BITS-1:0]       i_cfg_wr_data,
    input  logic                       i_in_valid,
    output logic                       o_in_stall,
    input  logic [IN_BITS-1:0]         i_density,
    input  logic signed [VEL_BITS-1:0] i_velocity,
    input  logic [IN_BITS-1:0]         i_pressure,
    input  logic                       i_row_end,
    output logic                       o_out_valid,
    input  logic                       i_out_stall,
    output logic signed [OUT_BITS-1:0] o_mass_out,
    output logic signed [OUT_BITS-1:0] o_momentum_out,
    output logic signed [OUT_BITS-1:0] o_energy_out,
    output logic                       o_boundary_cell,
    output logic                       o_overflow,
    output logic                       o_last_of_row
);

    localparam int CELL_BITS = 2 * NUM_VARS * WORD_BITS + 2;

    logic [STEP_BITS-1:0] r_step_factor, n_step_factor;
    logic                 q_push;
    logic                 q_pop;
    logic [CELL_BITS-1:0] q_in;
    logic [CELL_BITS-1:0] q_out;
    t_q_flags             q_flags;

    always_comb begin
        n_step_factor = r_step_factor;
        if (i_cfg_wr_en) begin
            n_step_factor = (i_cfg_wr_data > STEP_MAX) ? STEP_MAX : i_cfg_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step_factor <= '0;
        end else begin
            r_step_factor <= n_step_factor;
        end
    end

    elf_front #(
        .WORD_BITS (WORD_BITS),
        .FRAC_BITS (FRAC_BITS)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_density  (i_density),
        .i_velocity (i_velocity),
        .i_pressure (i_pressure),
        .i_row_end  (i_row_end),
        .o_push     (q_push),
        .o_cell     (q_in),
        .i_q_flags  (q_flags)
    );

    elf_queue #(
        .DATA_BITS (CELL_BITS)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_data  (q_in),
        .i_pop   (q_pop),
        .o_data  (q_out),
        .o_flags (q_flags)
    );

    elf_back #(
        .WORD_BITS (WORD_BITS)
    ) u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_step_factor   (r_step_factor),
        .i_cell          (q_out),
        .i_q_flags       (q_flags),
        .o_pop           (q_pop),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_mass_out      (o_mass_out),
        .o_momentum_out  (o_momentum_out),
        .o_energy_out    (o_energy_out),
        .o_boundary_cell (o_boundary_cell),
        .o_overflow      (o_overflow),
        .o_last_of_row   (o_last_of_row)
    );

endmodule

[hw/rtl/elf_mul.sv]
// ----------------------------------------------------------------------------
// elf_mul
// Chunk-serial sign-magnitude multiplier with right shift and word saturation.
// ----------------------------------------------------------------------------
module elf_mul
    import elf_pkg::*;
#(
    parameter int WORD_BITS = WORD_BITS_DEF,
    parameter int SHIFT     = FRAC_BITS_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [WORD_BITS:0]          i_a_mag,
    input  logic [MUL_B_BITS-1:0]       i_b_mag,
    input  logic                        i_neg,
    output logic                        o_done,
    output logic signed [WORD_BITS-1:0] o_prod,
    output logic                        o_ov
);

    localparam int A_BITS    = WORD_BITS + 1;
    localparam int N_CHUNKS  = (A_BITS + MUL_CHUNK - 1) / MUL_CHUNK;
    localparam int PAD_BITS  = N_CHUNKS * MUL_CHUNK;
    localparam int PROD_BITS = PAD_BITS + MUL_B_BITS;
    localparam int PART_BITS = MUL_CHUNK + MUL_B_BITS;
    localparam int CNT_BITS  = (N_CHUNKS > 1) ? $clog2(N_CHUNKS) : 1;

    localparam logic [PROD_BITS-1:0] LIM_POS =
        {{(PROD_BITS - WORD_BITS + 1){1'b0}}, {(WORD_BITS - 1){1'b1}}};
    localparam logic [PROD_BITS-1:0] LIM_NEG = LIM_POS + PROD_BITS'(1);
    localparam logic [WORD_BITS-1:0] W_MAX   = {1'b0, {(WORD_BITS - 1){1'b1}}};
    localparam logic [WORD_BITS-1:0] W_MIN   = {1'b1, {(WORD_BITS - 1){1'b0}}};

    logic [PAD_BITS-1:0]   r_a;
    logic [MUL_B_BITS-1:0] r_b;
    logic [PROD_BITS-1:0]  r_acc;
    logic [CNT_BITS-1:0]   r_cnt;
    logic                  r_busy;
    logic                  r_done;
    logic                  r_neg;

    logic [PART_BITS-1:0]  part;
    logic [PROD_BITS-1:0]  n_acc;
    logic [PROD_BITS-1:0]  mag;

    always_comb begin
        part  = r_a[PAD_BITS-1 -: MUL_CHUNK] * r_b;
        n_acc = (r_acc << MUL_CHUNK) + PROD_BITS'(part);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + CNT_BITS'(1);
                if (r_cnt == CNT_BITS'(N_CHUNKS - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_a   <= PAD_BITS'(i_a_mag);
            r_b   <= i_b_mag;
            r_neg <= i_neg;
            r_acc <= '0;
        end else if (r_busy) begin
            r_a   <= r_a << MUL_CHUNK;
            r_acc <= n_acc;
        end
    end

    always_comb begin
        mag  = r_acc >> SHIFT;
        o_ov = r_neg ? (mag > LIM_NEG) : (mag > LIM_POS);
        if (o_ov) begin
            o_prod = r_neg ? W_MIN : W_MAX;
        end else begin
            o_prod = r_neg ? -mag[WORD_BITS-1:0] : mag[WORD_BITS-1:0];
        end
    end

    assign o_done = r_done;

endmodule

[hw/rtl/elf_front.sv]
// ----------------------------------------------------------------------------
// elf_front
// Accepts cells and forms their conserved and flux vectors for the queue.
// ----------------------------------------------------------------------------
module elf_front
    import elf_pkg::*;
#(
    parameter int WORD_BITS = WORD_BITS_DEF,
    parameter int FRAC_BITS = FRAC_BITS_DEF,
    localparam int CELL_BITS = 2 * NUM_VARS * WORD_BITS + 2
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_in_valid,
    output logic                       o_in_stall,
    input  logic [IN_BITS-1:0]         i_density,
    input  logic signed [VEL_BITS-1:0] i_velocity,
    input  logic [IN_BITS-1:0]         i_pressure,
    input  logic                       i_row_end,
    output logic                       o_push,
    output logic [CELL_BITS-1:0]       o_cell,
    input  t_q_flags                   i_q_flags
);

    localparam int A_BITS = WORD_BITS + 1;

    t_front_state r_state, n_state;

    logic signed [WORD_BITS-1:0] r_rho, n_rho;
    logic signed [WORD_BITS-1:0] r_vel, n_vel;
    logic signed [WORD_BITS-1:0] r_p, n_p;
    logic signed [WORD_BITS-1:0] r_ru, n_ru;
    logic signed [WORD_BITS-1:0] r_ru2, n_ru2;
    logic signed [WORD_BITS-1:0] r_re, n_re;
    logic signed [WORD_BITS-1:0] r_f1, n_f1;
    logic signed [WORD_BITS-1:0] r_f2, n_f2;
    logic                        r_ov, n_ov;
    logic                        r_last, n_last;

    logic                        mul_start;
    logic [A_BITS-1:0]           mul_a;
    logic [MUL_B_BITS-1:0]       mul_b;
    logic                        mul_neg;
    logic                        mul_done;
    logic signed [WORD_BITS-1:0] mul_prod;
    logic                        mul_ov;

    t_sat sat_rho, sat_vel, sat_p, sat_a, sat_b;

    logic signed [EXT_BITS-1:0] vel_ext, p_ext, ru2_ext, re_ext, prod_ext, ru2_half;
    logic [MUL_B_BITS-1:0]      vel_mag;

    elf_mul #(
        .WORD_BITS (WORD_BITS),
        .SHIFT     (FRAC_BITS)
    ) u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (mul_start),
        .i_a_mag (mul_a),
        .i_b_mag (mul_b),
        .i_neg   (mul_neg),
        .o_done  (mul_done),
        .o_prod  (mul_prod),
        .o_ov    (mul_ov)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= F_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rho  <= n_rho;
        r_vel  <= n_vel;
        r_p    <= n_p;
        r_ru   <= n_ru;
        r_ru2  <= n_ru2;
        r_re   <= n_re;
        r_f1   <= n_f1;
        r_f2   <= n_f2;
        r_ov   <= n_ov;
        r_last <= n_last;
    end

    always_comb begin
        n_state   = r_state;
        n_rho     = r_rho;
        n_vel     = r_vel;
        n_p       = r_p;
        n_ru      = r_ru;
        n_ru2     = r_ru2;
        n_re      = r_re;
        n_f1      = r_f1;
        n_f2      = r_f2;
        n_ov      = r_ov;
        n_last    = r_last;
        mul_start = 1'b0;
        mul_a     = '0;
        mul_b     = '0;
        mul_neg   = 1'b0;
        o_push    = 1'b0;

        sat_rho  = sat_word(EXT_BITS'(i_density), WORD_BITS);
        sat_vel  = sat_word(EXT_BITS'(i_velocity), WORD_BITS);
        sat_p    = sat_word(EXT_BITS'(i_pressure), WORD_BITS);

        vel_ext  = EXT_BITS'(r_vel);
        p_ext    = EXT_BITS'(r_p);
        ru2_ext  = EXT_BITS'(r_ru2);
        re_ext   = EXT_BITS'(r_re);
        prod_ext = EXT_BITS'(mul_prod);
        vel_mag  = MUL_B_BITS'(abs_ext(vel_ext));
        ru2_half = (ru2_ext + ((ru2_ext < EXT_ZERO) ? EXT_ONE : EXT_ZERO)) >>> 1;

        sat_a = sat_word((p_ext <<< 1) + (p_ext >>> 1), WORD_BITS);
        sat_b = sat_word(ru2_ext + p_ext, WORD_BITS);

        case (r_state)
            F_IDLE: begin
                if (i_in_valid) begin
                    n_rho     = sat_rho.val[WORD_BITS-1:0];
                    n_vel     = sat_vel.val[WORD_BITS-1:0];
                    n_p       = sat_p.val[WORD_BITS-1:0];
                    n_ov      = sat_rho.ov | sat_vel.ov | sat_p.ov;
                    n_last    = i_row_end;
                    mul_start = 1'b1;
                    mul_a     = A_BITS'(sat_rho.val);
                    mul_b     = MUL_B_BITS'(abs_ext(sat_vel.val));
                    mul_neg   = sat_vel.val < EXT_ZERO;
                    n_state   = F_MUL1;
                end
            end
            F_MUL1: begin
                if (mul_done) begin
                    n_ru      = mul_prod;
                    n_ov      = r_ov | mul_ov;
                    mul_start = 1'b1;
                    mul_a     = A_BITS'(abs_ext(prod_ext));
                    mul_b     = vel_mag;
                    mul_neg   = mul_prod[WORD_BITS-1] ^ r_vel[WORD_BITS-1];
                    n_state   = F_MUL2;
                end
            end
            F_MUL2: begin
                if (mul_done) begin
                    n_ru2   = mul_prod;
                    n_ov    = r_ov | mul_ov;
                    n_state = F_ADD1;
                end
            end
            F_ADD1: begin
                n_re    = sat_a.val[WORD_BITS-1:0];
                n_f1    = sat_b.val[WORD_BITS-1:0];
                n_ov    = r_ov | sat_a.ov | sat_b.ov;
                n_state = F_ADD2;
            end
            F_ADD2: begin
                sat_a   = sat_word(re_ext + ru2_half, WORD_BITS);
                n_re    = sat_a.val[WORD_BITS-1:0];
                n_ov    = r_ov | sat_a.ov;
                n_state = F_ADD3;
            end
            F_ADD3: begin
                sat_a     = sat_word(re_ext + p_ext, WORD_BITS);
                n_ov      = r_ov | sat_a.ov;
                mul_start = 1'b1;
                mul_a     = A_BITS'(abs_ext(sat_a.val));
                mul_b     = vel_mag;
                mul_neg   = (sat_a.val < EXT_ZERO) ^ r_vel[WORD_BITS-1];
                n_state   = F_MUL3;
            end
            F_MUL3: begin
                if (mul_done) begin
                    n_f2    = mul_prod;
                    n_ov    = r_ov | mul_ov;
                    n_state = F_PUSH;
                end
            end
            F_PUSH: begin
                if (!i_q_flags.full) begin
                    o_push  = 1'b1;
                    n_state = F_IDLE;
                end
            end
            default: begin
                n_state = F_IDLE;
            end
        endcase
    end

    // flux above conserved, each with its lowest variable in the lowest bits
    assign o_cell     = {r_ov, r_last, r_f2, r_f1, r_ru, r_re, r_ru, r_rho};
    assign o_in_stall = (r_state != F_IDLE);

endmodule

[hw/rtl/elf_queue.sv]
// ----------------------------------------------------------------------------
// elf_queue
// Short first-in first-out queue of formed cells between front and back.
// ----------------------------------------------------------------------------
module elf_queue
    import elf_pkg::*;
#(
    parameter int DATA_BITS = 2 * NUM_VARS * WORD_BITS_DEF + 2
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_push,
    input  logic [DATA_BITS-1:0] i_data,
    input  logic                 i_pop,
    output logic [DATA_BITS-1:0] o_data,
    output t_q_flags             o_flags
);

    localparam int PTR_BITS = $clog2(Q_DEPTH);

    logic [DATA_BITS-1:0] r_mem [Q_DEPTH];
    logic [PTR_BITS-1:0]  r_wr_ptr, n_wr_ptr;
    logic [PTR_BITS-1:0]  r_rd_ptr, n_rd_ptr;
    logic [PTR_BITS:0]    r_count, n_count;
    logic                 push_ok;
    logic                 pop_ok;

    always_comb begin
        o_flags.full  = (r_count == (PTR_BITS + 1)'(Q_DEPTH));
        o_flags.empty = (r_count == '0);
        push_ok       = i_push && !o_flags.full;
        pop_ok        = i_pop && !o_flags.empty;
        n_wr_ptr      = push_ok ? r_wr_ptr + PTR_BITS'(1) : r_wr_ptr;
        n_rd_ptr      = pop_ok ? r_rd_ptr + PTR_BITS'(1) : r_rd_ptr;
        n_count       = r_count + (PTR_BITS + 1)'(push_ok) - (PTR_BITS + 1)'(pop_ok);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push_ok) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    assign o_data = r_mem[r_rd_ptr];

endmodule

[hw/rtl/elf_back.sv]
// ----------------------------------------------------------------------------
// elf_back
// Neighbour window, Lax-Friedrichs update of interior cells and result word.
// ----------------------------------------------------------------------------
module elf_back
    import elf_pkg::*;
#(
    parameter int WORD_BITS = WORD_BITS_DEF,
    localparam int CELL_BITS = 2 * NUM_VARS * WORD_BITS + 2
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic [STEP_BITS-1:0]       i_step_factor,
    input  logic [CELL_BITS-1:0]       i_cell,
    input  t_q_flags                   i_q_flags,
    output logic                       o_pop,
    output logic                       o_out_valid,
    input  logic                       i_out_stall,
    output logic signed [OUT_BITS-1:0] o_mass_out,
    output logic signed [OUT_BITS-1:0] o_momentum_out,
    output logic signed [OUT_BITS-1:0] o_energy_out,
    output logic                       o_boundary_cell,
    output logic                       o_overflow,
    output logic                       o_last_of_row
);

    localparam int A_BITS   = WORD_BITS + 1;
    localparam int VEC_BITS = NUM_VARS * WORD_BITS;
    localparam int IDX_BITS = $clog2(NUM_VARS);
    localparam logic [1:0] SEEN_NONE = 2'd0;
    localparam logic [1:0] SEEN_FULL = 2'd2;

    t_back_state r_state, n_state;

    logic [CELL_BITS-1:0]                r_cur, n_cur;
    logic [NUM_VARS-1:0][WORD_BITS-1:0]  r_cw_old, n_cw_old, r_cw_new, n_cw_new;
    logic [NUM_VARS-1:0][WORD_BITS-1:0]  r_fw_old, n_fw_old, r_fw_new, n_fw_new;
    logic [1:0]                          r_wov, n_wov;
    logic [1:0]                          r_seen, n_seen;
    logic [IDX_BITS-1:0]                 r_j, n_j;
    logic signed [WORD_BITS-1:0]         r_mean, n_mean;
    logic [NUM_VARS-1:0][WORD_BITS-1:0]  r_res, n_res;
    logic                                r_iov, n_iov;

    logic                                r_out_valid, n_out_valid;
    logic [NUM_VARS-1:0][OUT_BITS-1:0]   r_out_vals, n_out_vals;
    logic                                r_bnd, n_bnd;
    logic                                r_ovf, n_ovf;
    logic                                r_last, n_last;

    logic [NUM_VARS-1:0][WORD_BITS-1:0]  cur_u, cur_f, src;
    logic                                cur_last, cur_ov;
    logic                                src_bnd, src_ov, src_last, load, out_free;
    logic [1:0]                          seen_c;
    logic signed [EXT_BITS-1:0]          sum_ext, mean_ext, diff_ext;
    t_sat                                sat_r;
    t_sat                                clamp [NUM_VARS];

    logic                        mul_start;
    logic [A_BITS-1:0]           mul_a;
    logic [MUL_B_BITS-1:0]       mul_b;
    logic                        mul_neg;
    logic                        mul_done;
    logic signed [WORD_BITS-1:0] mul_prod;
    logic                        mul_ov;

    elf_mul #(
        .WORD_BITS (WORD_BITS),
        .SHIFT     (STEP_FRAC)
    ) u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (mul_start),
        .i_a_mag (mul_a),
        .i_b_mag (mul_b),
        .i_neg   (mul_neg),
        .o_done  (mul_done),
        .o_prod  (mul_prod),
        .o_ov    (mul_ov)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= B_IDLE;
            r_seen      <= SEEN_NONE;
            r_wov       <= '0;
            r_cw_old    <= '0;
            r_cw_new    <= '0;
            r_fw_old    <= '0;
            r_fw_new    <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_seen      <= n_seen;
            r_wov       <= n_wov;
            r_cw_old    <= n_cw_old;
            r_cw_new    <= n_cw_new;
            r_fw_old    <= n_fw_old;
            r_fw_new    <= n_fw_new;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cur      <= n_cur;
        r_j        <= n_j;
        r_mean     <= n_mean;
        r_res      <= n_res;
        r_iov      <= n_iov;
        r_out_vals <= n_out_vals;
        r_bnd      <= n_bnd;
        r_ovf      <= n_ovf;
        r_last     <= n_last;
    end

    always_comb begin
        cur_u    = r_cur[VEC_BITS-1:0];
        cur_f    = r_cur[2*VEC_BITS-1:VEC_BITS];
        cur_last = r_cur[2*VEC_BITS];
        cur_ov   = r_cur[2*VEC_BITS+1];
        seen_c   = (r_seen > SEEN_FULL) ? SEEN_FULL : r_seen;
        out_free = !r_out_valid || !i_out_stall;

        n_state   = r_state;
        n_cur     = r_cur;
        n_cw_old  = r_cw_old;
        n_cw_new  = r_cw_new;
        n_fw_old  = r_fw_old;
        n_fw_new  = r_fw_new;
        n_wov     = r_wov;
        n_seen    = r_seen;
        n_j       = r_j;
        n_mean    = r_mean;
        n_res     = r_res;
        n_iov     = r_iov;
        o_pop     = 1'b0;
        mul_start = 1'b0;
        mul_a     = '0;
        mul_b     = '0;
        mul_neg   = 1'b0;
        load      = 1'b0;
        src       = r_res;
        src_bnd   = 1'b0;
        src_ov    = r_iov;
        src_last  = 1'b0;

        sum_ext  = EXT_BITS'($signed(r_cw_old[r_j])) + EXT_BITS'($signed(cur_u[r_j]));
        mean_ext = (sum_ext + ((sum_ext < EXT_ZERO) ? EXT_ONE : EXT_ZERO)) >>> 1;
        diff_ext = EXT_BITS'($signed(cur_f[r_j])) - EXT_BITS'($signed(r_fw_old[r_j]));
        sat_r    = sat_word(EXT_BITS'(r_mean) - EXT_BITS'(mul_prod), WORD_BITS);

        case (r_state)
            B_IDLE: begin
                if (!i_q_flags.empty) begin
                    o_pop   = 1'b1;
                    n_cur   = i_cell;
                    n_state = B_ROUTE;
                end
            end
            B_ROUTE: begin
                n_iov = cur_ov | r_wov[0];
                n_j   = '0;
                if (seen_c == SEEN_NONE) begin
                    n_state = B_BOUNDARY;
                end else if (seen_c == SEEN_FULL) begin
                    n_state = B_MSTART;
                end else if (cur_last) begin
                    n_state = B_BOUNDARY;
                end else begin
                    n_state = B_SHIFT;
                end
            end
            B_MSTART: begin
                n_mean    = mean_ext[WORD_BITS-1:0];
                mul_start = 1'b1;
                mul_a     = A_BITS'(abs_ext(diff_ext));
                mul_b     = MUL_B_BITS'(i_step_factor);
                mul_neg   = diff_ext < EXT_ZERO;
                n_state   = B_MWAIT;
            end
            B_MWAIT: begin
                if (mul_done) begin
                    n_res[r_j] = sat_r.val[WORD_BITS-1:0];
                    n_iov      = r_iov | mul_ov | sat_r.ov;
                    if (r_j == IDX_BITS'(NUM_VARS - 1)) begin
                        n_state = B_INTERIOR;
                    end else begin
                        n_j     = r_j + IDX_BITS'(1);
                        n_state = B_MSTART;
                    end
                end
            end
            B_INTERIOR: begin
                if (out_free) begin
                    load    = 1'b1;
                    n_state = cur_last ? B_BOUNDARY : B_SHIFT;
                end
            end
            B_BOUNDARY: begin
                if (out_free) begin
                    load     = 1'b1;
                    src      = cur_u;
                    src_bnd  = 1'b1;
                    src_ov   = cur_ov;
                    src_last = cur_last;
                    n_state  = B_SHIFT;
                end
            end
            B_SHIFT: begin
                n_cw_old = r_cw_new;
                n_cw_new = cur_u;
                n_fw_old = r_fw_new;
                n_fw_new = cur_f;
                n_wov    = {cur_ov, r_wov[1]};
                if (cur_last) begin
                    n_seen = SEEN_NONE;
                end else if (seen_c < SEEN_FULL) begin
                    n_seen = seen_c + 2'd1;
                end else begin
                    n_seen = SEEN_FULL;
                end
                n_state = B_IDLE;
            end
            default: begin
                n_state = B_IDLE;
            end
        endcase
    end

    // clamp to the result field and load the output word
    always_comb begin
        n_out_vals = r_out_vals;
        n_bnd      = r_bnd;
        n_ovf      = r_ovf;
        n_last     = r_last;
        for (int j = 0; j < NUM_VARS; j++) begin
            clamp[j] = sat_word(EXT_BITS'($signed(src[j])), OUT_BITS);
        end
        if (load) begin
            n_ovf = src_ov;
            for (int j = 0; j < NUM_VARS; j++) begin
                n_out_vals[j] = clamp[j].val[OUT_BITS-1:0];
                n_ovf         = n_ovf | clamp[j].ov;
            end
            n_bnd  = src_bnd;
            n_last = src_last;
        end
        n_out_valid = load || (r_out_valid && i_out_stall);
    end

    assign o_out_valid     = r_out_valid;
    assign o_mass_out      = r_out_vals[0];
    assign o_momentum_out  = r_out_vals[1];
    assign o_energy_out    = r_out_vals[2];
    assign o_boundary_cell = r_bnd;
    assign o_overflow      = r_ovf;
    assign o_last_of_row   = r_last;

endmodule

[bench/euler_lax_friedrichs_step_tb.sv]
// ----------------------------------------------------------------------------
// euler_lax_friedrichs_step_tb
// Self-checking bench for the streamed Lax-Friedrichs step. A short directed
// table of rows (single-cell extremes with hand-worked results, then two-,
// three- and longer rows against the predictor) is followed by random rows
// under a series of step_factor settings. Both channels idle and stall at
// random, the output is held off once for a long stretch, and every word
// that leaves the block is compared field by field with its expected word,
// worked out by hand or by a bit-exact fixed-point predictor.
// ----------------------------------------------------------------------------
module euler_lax_friedrichs_step_tb
    import elf_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    typedef logic signed [63:0] t_wide;

    typedef struct packed {
        logic [IN_BITS-1:0]  density;
        logic [VEL_BITS-1:0] velocity;
        logic [IN_BITS-1:0]  pressure;
        logic                row_end;
    } t_cell_in;

    typedef struct packed {
        logic [OUT_BITS-1:0] mass;
        logic [OUT_BITS-1:0] momentum;
        logic [OUT_BITS-1:0] energy;
        logic                boundary;
        logic                ovf;
        logic                last;
    } t_cell_out;

    typedef struct {
        t_cell_in  din;
        bit        typed;
        t_cell_out want;
    } t_stim_row;

    localparam t_wide WORD_HI     = 64'sh7fff_ffff;
    localparam t_wide WORD_LO     = -64'sh8000_0000;
    localparam int    IDLE_PCT    = 8;
    localparam int    PHASE_CELLS = 210;
    localparam int    HOLD_AT     = 400;
    localparam int    HOLD_CYCLES = 300;
    localparam int    QUIET_FROM  = 900;
    localparam int    QUIET_TO    = 1200;
    localparam int    SETTLE      = 64;

    logic                i_clk = 1'b0;
    logic                i_rst_n;
    logic                i_cfg_wr_en;
    logic [STEP_BITS-1:0] i_cfg_wr_data;
    logic                i_in_valid;
    logic                o_in_stall;
    logic [IN_BITS-1:0]  i_density;
    logic signed [VEL_BITS-1:0] i_velocity;
    logic [IN_BITS-1:0]  i_pressure;
    logic                i_row_end;
    logic                o_out_valid;
    logic                i_out_stall;
    logic signed [OUT_BITS-1:0] o_mass_out;
    logic signed [OUT_BITS-1:0] o_momentum_out;
    logic signed [OUT_BITS-1:0] o_energy_out;
    logic                o_boundary_cell;
    logic                o_overflow;
    logic                o_last_of_row;

    // predictor state: window of two cells, row count, step factor
    t_wide     held_u[6];
    t_wide     held_f[6];
    bit        held_ovf[2];
    int        held_count;
    t_wide     step_q16;

    t_cell_out awaited_updates[$];
    t_stim_row directed_rows[$];
    bit        offer_typed;
    t_cell_out offer_want;
    int        cells_taken;
    int        mismatches;

    euler_lax_friedrichs_step dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_wr_en     (i_cfg_wr_en),
        .i_cfg_wr_data   (i_cfg_wr_data),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_density       (i_density),
        .i_velocity      (i_velocity),
        .i_pressure      (i_pressure),
        .i_row_end       (i_row_end),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_mass_out      (o_mass_out),
        .o_momentum_out  (o_momentum_out),
        .o_energy_out    (o_energy_out),
        .o_boundary_cell (o_boundary_cell),
        .o_overflow      (o_overflow),
        .o_last_of_row   (o_last_of_row)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    function automatic t_wide clamp_word(input t_wide x, inout bit ov);
        if (x > WORD_HI) begin
            ov = 1'b1;
            return WORD_HI;
        end
        if (x < WORD_LO) begin
            ov = 1'b1;
            return WORD_LO;
        end
        return x;
    endfunction

    // exact product of magnitudes, shifted down toward zero, then saturated
    function automatic t_wide fixed_mul(input t_wide a, input t_wide b, input int sh,
                                        inout bit ov);
        logic [63:0]  ma;
        logic [63:0]  mb;
        logic [127:0] mag;
        ma  = (a < 0) ? 64'(-a) : 64'(a);
        mb  = (b < 0) ? 64'(-b) : 64'(b);
        mag = ({64'd0, ma} * {64'd0, mb}) >> sh;
        if ((a < 0) != (b < 0)) begin
            if (mag > 128'h8000_0000) begin
                ov = 1'b1;
                return WORD_LO;
            end
            return -t_wide'(mag[63:0]);
        end
        if (mag > 128'h7fff_ffff) begin
            ov = 1'b1;
            return WORD_HI;
        end
        return t_wide'(mag[63:0]);
    endfunction

    function automatic t_cell_out pack_result(input t_wide m, input t_wide mo, input t_wide e,
                                              input bit b, input bit ov, input bit last);
        t_cell_out r;
        r.mass     = m[31:0];
        r.momentum = mo[31:0];
        r.energy   = e[31:0];
        r.boundary = b;
        r.ovf      = ov;
        r.last     = last;
        return r;
    endfunction

    // one cell through the window; returns the number of words it releases
    function automatic int advance_cell(input t_cell_in c, output t_cell_out first,
                                        output t_cell_out second);
        t_wide cu[3];
        t_wide cf[3];
        t_wide res[3];
        t_wide rho, vel, p, ru, ru2, re, mean, diff, t;
        bit    cov;
        bit    iov;
        int    seen;
        int    n;
        int    j;
        cov    = 1'b0;
        first  = '0;
        second = '0;
        rho = t_wide'(c.density);
        vel = t_wide'($signed(c.velocity));
        p   = t_wide'(c.pressure);
        ru  = fixed_mul(rho, vel, 16, cov);
        ru2 = fixed_mul(ru, vel, 16, cov);
        re  = clamp_word(64'sd2 * p + p / 64'sd2, cov);
        re  = clamp_word(re + ru2 / 64'sd2, cov);
        cu[0] = rho;
        cu[1] = ru;
        cu[2] = re;
        cf[0] = ru;
        cf[1] = clamp_word(ru2 + p, cov);
        cf[2] = fixed_mul(clamp_word(re + p, cov), vel, 16, cov);

        seen = (held_count > 2) ? 2 : held_count;
        n    = 0;
        if (seen == 0) begin
            first = pack_result(cu[0], cu[1], cu[2], 1'b1, cov, c.row_end);
            n = 1;
        end else begin
            if (seen == 2) begin
                iov = cov || held_ovf[0];
                for (j = 0; j < 3; j++) begin
                    mean   = (held_u[j] + cu[j]) / 64'sd2;
                    diff   = cf[j] - held_f[j];
                    t      = fixed_mul(diff, step_q16, STEP_FRAC, iov);
                    res[j] = clamp_word(mean - t, iov);
                end
                first = pack_result(res[0], res[1], res[2], 1'b0, iov, 1'b0);
                n = 1;
            end
            if (c.row_end) begin
                if (n == 0) begin
                    first = pack_result(cu[0], cu[1], cu[2], 1'b1, cov, 1'b1);
                end else begin
                    second = pack_result(cu[0], cu[1], cu[2], 1'b1, cov, 1'b1);
                end
                n++;
            end
        end

        for (j = 0; j < 3; j++) begin
            held_u[j]     = held_u[3 + j];
            held_f[j]     = held_f[3 + j];
            held_u[3 + j] = cu[j];
            held_f[3 + j] = cf[j];
        end
        held_ovf[0] = held_ovf[1];
        held_ovf[1] = cov;
        held_count  = c.row_end ? 0 : ((seen < 2) ? seen + 1 : 2);
        return n;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        mismatches++;
        $display("mismatch %0s: got %h want %h at %0t", what, got, want, $time);
    endtask

    task automatic check_word(input t_cell_out got);
        t_cell_out want;
        if (awaited_updates.size() == 0) begin
            report_mismatch("word with nothing awaited", got.mass, 32'd0);
        end else begin
            want = awaited_updates.pop_front();
            if (got.mass !== want.mass)
                report_mismatch("mass", got.mass, want.mass);
            if (got.momentum !== want.momentum)
                report_mismatch("momentum", got.momentum, want.momentum);
            if (got.energy !== want.energy)
                report_mismatch("energy", got.energy, want.energy);
            if (got.boundary !== want.boundary)
                report_mismatch("boundary", 32'(got.boundary), 32'(want.boundary));
            if (got.ovf !== want.ovf)
                report_mismatch("overflow", 32'(got.ovf), 32'(want.ovf));
            if (got.last !== want.last)
                report_mismatch("last_of_row", 32'(got.last), 32'(want.last));
        end
    endtask

    // accepted cells feed the predictor, accepted words are checked
    always @(posedge i_clk) begin : watch
        t_cell_in  c;
        t_cell_out r0;
        t_cell_out r1;
        t_cell_out got;
        int        n;
        if (i_rst_n) begin
            if (i_in_valid && !o_in_stall) begin
                c.density  = i_density;
                c.velocity = i_velocity;
                c.pressure = i_pressure;
                c.row_end  = i_row_end;
                n = advance_cell(c, r0, r1);
                if (offer_typed) begin
                    awaited_updates.push_back(offer_want);
                end else begin
                    if (n > 0) awaited_updates.push_back(r0);
                    if (n > 1) awaited_updates.push_back(r1);
                end
                cells_taken++;
            end
            if (o_out_valid && !i_out_stall) begin
                got.mass     = o_mass_out;
                got.momentum = o_momentum_out;
                got.energy   = o_energy_out;
                got.boundary = o_boundary_cell;
                got.ovf      = o_overflow;
                got.last     = o_last_of_row;
                check_word(got);
            end
        end
    end

    function automatic bit quiet_window();
        return cells_taken >= QUIET_FROM && cells_taken < QUIET_TO;
    endfunction

    // output side: random stalls, one long hold-off
    initial begin : receiver
        int hold_left;
        bit held;
        hold_left   = 0;
        held        = 1'b0;
        i_out_stall = 1'b0;
        forever begin
            @(negedge i_clk);
            if (!held && cells_taken >= HOLD_AT) begin
                held      = 1'b1;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                i_out_stall <= 1'b1;
                hold_left--;
            end else begin
                i_out_stall <= !quiet_window() && ($urandom_range(99) < IDLE_PCT);
            end
        end
    end

    task automatic offer_cell(input t_cell_in c, input bit typed, input t_cell_out want);
        while (!quiet_window() && $urandom_range(99) < IDLE_PCT) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid  <= 1'b1;
        i_density   <= c.density;
        i_velocity  <= c.velocity;
        i_pressure  <= c.pressure;
        i_row_end   <= c.row_end;
        offer_typed <= typed;
        offer_want  <= want;
        do @(posedge i_clk); while (o_in_stall);
        @(negedge i_clk);
    endtask

    function automatic void add_row(input logic [30:0] d, input logic [31:0] v,
                                    input logic [30:0] p, input bit row_end);
        t_stim_row r;
        r.din   = '{d, v, p, row_end};
        r.typed = 1'b0;
        r.want  = '0;
        directed_rows.push_back(r);
    endfunction

    // single-cell row with its boundary word worked out by hand
    function automatic void add_typed(input logic [30:0] d, input logic [31:0] v,
                                      input logic [30:0] p, input logic [31:0] m,
                                      input logic [31:0] mo, input logic [31:0] e,
                                      input bit ov);
        t_stim_row r;
        r.din   = '{d, v, p, 1'b1};
        r.typed = 1'b1;
        r.want  = '{m, mo, e, 1'b1, ov, 1'b1};
        directed_rows.push_back(r);
    endfunction

    function automatic t_cell_in random_cell(input bit row_end);
        t_cell_in c;
        case ($urandom_range(9))
            0: begin
                c.density  = 31'($urandom);
                c.velocity = $urandom;
                c.pressure = 31'($urandom);
            end
            1: begin
                c.density  = $urandom_range(1) ? 31'h7fff_ffff : 31'($urandom_range(255));
                c.velocity = $urandom_range(1) ? 32'h8000_0000 : 32'h7fff_ffff;
                c.pressure = $urandom_range(1) ? 31'h7fff_ffff : 31'($urandom_range(255));
            end
            default: begin
                c.density  = 31'($urandom_range(32'h000a_0000, 32'h0000_1000));
                c.velocity = $urandom_range(32'h0008_0000) - 32'h0004_0000;
                c.pressure = 31'($urandom_range(32'h000a_0000, 32'h0000_1000));
            end
        endcase
        c.row_end = row_end;
        return c;
    endfunction

    function automatic int random_row_len();
        int roll;
        roll = $urandom_range(99);
        if (roll < 6) return 1;
        if (roll < 12) return 2;
        if (roll < 16) return $urandom_range(40, 20);
        return $urandom_range(12, 3);
    endfunction

    task automatic run_random_rows(input int quota);
        int        sent;
        int        len;
        int        k;
        t_cell_out none;
        sent = 0;
        none = '0;
        while (sent < quota) begin
            len = random_row_len();
            for (k = 0; k < len; k++) begin
                offer_cell(random_cell(k == len - 1), 1'b0, none);
            end
            sent += len;
        end
    endtask

    // wait for every awaited word, then let the back end finish its shift
    task automatic settle();
        i_in_valid <= 1'b0;
        while (awaited_updates.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(negedge i_clk);
    endtask

    task automatic write_step(input logic [STEP_BITS-1:0] v);
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= v;
        step_q16       = (v > STEP_MAX) ? t_wide'(STEP_MAX) : t_wide'(v);
        @(negedge i_clk);
        i_cfg_wr_en   <= 1'b0;
    endtask

    initial begin : stimulus
        logic [STEP_BITS-1:0] step_plan[7];
        int                   i;
        i_rst_n       = 1'b0;
        i_cfg_wr_en   = 1'b0;
        i_cfg_wr_data = '0;
        i_in_valid    = 1'b0;
        i_density     = '0;
        i_velocity    = '0;
        i_pressure    = '0;
        i_row_end     = 1'b0;
        offer_typed   = 1'b0;
        offer_want    = '0;
        cells_taken   = 0;
        mismatches    = 0;
        for (i = 0; i < 6; i++) begin
            held_u[i] = 0;
            held_f[i] = 0;
        end
        held_ovf[0] = 1'b0;
        held_ovf[1] = 1'b0;
        held_count  = 0;
        step_q16    = 0;

        step_plan[0] = STEP_MAX;
        step_plan[1] = 17'h1_ffff;
        step_plan[2] = 17'h0_8000;
        step_plan[3] = STEP_BITS'($urandom_range(32'h1_0000));
        step_plan[4] = 17'd1;
        step_plan[5] = 17'd0;
        step_plan[6] = STEP_BITS'($urandom_range(32'h1_ffff));

        // single cells at the extremes, step factor still at reset
        add_typed(31'h0, 32'h0, 31'h0, 32'h0, 32'h0, 32'h0, 1'b0);
        add_typed(31'h1_0000, 32'h1_0000, 31'h1_0000,
                  32'h1_0000, 32'h1_0000, 32'h3_0000, 1'b0);
        add_typed(31'h7fff_ffff, 32'h2_0000, 31'h0,
                  32'h7fff_ffff, 32'h7fff_ffff, 32'h3fff_ffff, 1'b1);
        add_typed(31'h0, 32'h0, 31'h7fff_ffff, 32'h0, 32'h0, 32'h7fff_ffff, 1'b1);
        add_typed(31'h1_0000, 32'h8000_0000, 31'h0,
                  32'h1_0000, 32'h8000_0000, 32'h3fff_ffff, 1'b1);
        add_typed(31'h7fff_ffff, 32'h8000_0000, 31'h0,
                  32'h7fff_ffff, 32'h8000_0000, 32'h3fff_ffff, 1'b1);
        add_typed(31'h0, 32'h7fff_ffff, 31'h0, 32'h0, 32'h0, 32'h0, 1'b0);
        // two-cell row: both ends pass through
        add_row(31'h1_0000, 32'h1_0000, 31'h1_0000, 1'b0);
        add_row(31'h2_0000, 32'hffff_0000, 31'h0_8000, 1'b1);
        // shortest row with an interior cell
        add_row(31'h1_0000, 32'h0, 31'h1_0000, 1'b0);
        add_row(31'h0_8000, 32'h0_8000, 31'h2_0000, 1'b0);
        add_row(31'h0_4000, 32'hffff_8000, 31'h0_1999, 1'b1);
        // saturating cells inside a row
        add_row(31'h7fff_ffff, 32'h1_0000, 31'h7fff_ffff, 1'b0);
        add_row(31'h0, 32'h7fff_ffff, 31'h0, 1'b0);
        add_row(31'h7fff_ffff, 32'h8000_0000, 31'h7fff_ffff, 1'b0);
        add_row(31'h1_0000, 32'hffff_0000, 31'h1_0000, 1'b0);
        add_row(31'h0_8000, 32'h0000_1234, 31'h1_0000, 1'b1);
        // plain smooth row
        add_row(31'h1_0000, 32'h0_4000, 31'h1_0000, 1'b0);
        add_row(31'h1_2000, 32'h0_3000, 31'h0_e000, 1'b0);
        add_row(31'h1_4000, 32'h0_2000, 31'h0_c000, 1'b0);
        add_row(31'h1_6000, 32'h0_1000, 31'h0_a000, 1'b1);

        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        foreach (directed_rows[k]) begin
            offer_cell(directed_rows[k].din, directed_rows[k].typed, directed_rows[k].want);
        end
        run_random_rows(PHASE_CELLS);
        for (i = 0; i < 7; i++) begin
            settle();
            write_step(step_plan[i]);
            run_random_rows(PHASE_CELLS);
        end
        settle();

        if (mismatches == 0) begin
            $display("euler_lax_friedrichs_step verification clean");
        end else begin
            $display("euler_lax_friedrichs_step verification failed");
        end
        $finish;
    end

    initial begin : watchdog
        #4_000_000;
        $display("euler_lax_friedrichs_step verification failed");
        $finish;
    end

endmodule

[euler_lax_friedrichs_step.f]
hw/rtl/elf_pkg.sv
hw/rtl/elf_mul.sv
hw/rtl/elf_front.sv
hw/rtl/elf_queue.sv
hw/rtl/elf_back.sv
hw/rtl/euler_lax_friedrichs_step.sv
bench/euler_lax_friedrichs_step_tb.sv
